>>> hw/rtl/phu_pkg.sv
// ----------------------------------------------------------------------------
// phu_pkg
// Shared widths, constants, types and the arctangent table for the phase
// unwrapper.
// ----------------------------------------------------------------------------
package phu_pkg;

   localparam int SAMPLE_WIDTH      = 24;
   localparam int ANGLE_BITS        = 16;
   localparam int CORDIC_ITERATIONS = 16;
   localparam int TURN_COUNT_WIDTH  = 16;

   localparam int GUARD_SHIFT  = 40 - SAMPLE_WIDTH;
   // magnitude plus guard bits, two bits of CORDIC growth and a sign bit
   localparam int CORDIC_WIDTH = SAMPLE_WIDTH + GUARD_SHIFT + 3;
   localparam int ANGLE_ACC_WIDTH = 34;
   localparam int ITER_BITS    = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam int PHASE_WIDTH  = ANGLE_BITS + 1;
   localparam int UNWRAP_WIDTH = ANGLE_BITS + TURN_COUNT_WIDTH + 1;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_JUMP_THRESHOLD = 1'b0;

   localparam longint THRESH_RESET_L = ((longint'(280) << ANGLE_BITS) + 180) / 360;
   localparam logic [ANGLE_BITS-1:0] THRESH_RESET = THRESH_RESET_L[ANGLE_BITS-1:0];

   localparam logic signed [PHASE_WIDTH-1:0] HALF_TURN =
      PHASE_WIDTH'(longint'(1) << (ANGLE_BITS - 1));
   localparam logic signed [PHASE_WIDTH-1:0] QUARTER_TURN =
      PHASE_WIDTH'(longint'(1) << (ANGLE_BITS - 2));
   localparam logic signed [TURN_COUNT_WIDTH-1:0] TURN_MAX =
      TURN_COUNT_WIDTH'((longint'(1) << (TURN_COUNT_WIDTH - 1)) - 1);
   localparam logic signed [TURN_COUNT_WIDTH-1:0] TURN_MIN =
      TURN_COUNT_WIDTH'(-(longint'(1) << (TURN_COUNT_WIDTH - 1)));
   localparam logic signed [ANGLE_ACC_WIDTH-1:0] ANGLE_ROUND =
      ANGLE_ACC_WIDTH'(longint'(1) << (31 - ANGLE_BITS));

   typedef enum logic [1:0] {
      PHU_IDLE,
      PHU_ITER,
      PHU_RESOLVE
   } phu_state_type;

   // round(atan(2^-i) / (2 pi) * 2^32)
   function automatic logic signed [ANGLE_ACC_WIDTH-1:0] phu_atan(input logic [4:0] idx);
      logic signed [ANGLE_ACC_WIDTH-1:0] val;
      unique case (idx)
         5'd0:    val = 34'sd536870912;
         5'd1:    val = 34'sd316933406;
         5'd2:    val = 34'sd167458907;
         5'd3:    val = 34'sd85004756;
         5'd4:    val = 34'sd42667331;
         5'd5:    val = 34'sd21354465;
         5'd6:    val = 34'sd10679838;
         5'd7:    val = 34'sd5340245;
         5'd8:    val = 34'sd2670163;
         5'd9:    val = 34'sd1335087;
         5'd10:   val = 34'sd667544;
         5'd11:   val = 34'sd333772;
         5'd12:   val = 34'sd166886;
         5'd13:   val = 34'sd83443;
         5'd14:   val = 34'sd41722;
         5'd15:   val = 34'sd20861;
         5'd16:   val = 34'sd10430;
         5'd17:   val = 34'sd5215;
         5'd18:   val = 34'sd2608;
         5'd19:   val = 34'sd1304;
         5'd20:   val = 34'sd652;
         5'd21:   val = 34'sd326;
         5'd22:   val = 34'sd163;
         5'd23:   val = 34'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> hw/rtl/phu_req_if.sv
// ----------------------------------------------------------------------------
// phu_req_if
// Sample channel into the phase unwrapper: valid, ready and one complex sample.
// ----------------------------------------------------------------------------
interface phu_req_if;
   import phu_pkg::*;

   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] real_part;
   logic signed [SAMPLE_WIDTH-1:0] imag_part;
   logic                           restart;

   modport source (output valid, output real_part, output imag_part, output restart,
                   input ready);
   modport sink   (input valid, input real_part, input imag_part, input restart,
                   output ready);
endinterface

>>> hw/rtl/phu_rsp_if.sv
// ----------------------------------------------------------------------------
// phu_rsp_if
// Result channel out of the phase unwrapper: valid, ready and one phase result.
// ----------------------------------------------------------------------------
interface phu_rsp_if;
   import phu_pkg::*;

   logic                               valid;
   logic                               ready;
   logic signed [UNWRAP_WIDTH-1:0]     unwrapped_phase;
   logic signed [PHASE_WIDTH-1:0]      wrapped_phase;
   logic signed [TURN_COUNT_WIDTH-1:0] turn_count;
   logic                               indeterminate;

   modport source (output valid, output unwrapped_phase, output wrapped_phase,
                   output turn_count, output indeterminate, input ready);
   modport sink   (input valid, input unwrapped_phase, input wrapped_phase,
                   input turn_count, input indeterminate, output ready);
endinterface

>>> hw/rtl/phase_unwrapper.sv
// ----------------------------------------------------------------------------
// phase_unwrapper
// CORDIC vectoring atan2 of a complex sample followed by phase unwrapping with
// a saturating turn count.
//
//   channel    direction  transaction
//   req_chan   in         real_part, imag_part, restart
//   rsp_chan   out        unwrapped_phase, wrapped_phase, turn_count, indeterminate
//   csr_*      in/out     APB register access, jump_threshold at byte 0
//
// A sample passes through a load step, the CORDIC iterations on the shared
// add/shift unit and an unwrap step. Samples on an axis or at the origin skip
// the iterations.
// Reset clears the sequencer, the phase history and the turn count, and
// restores the default jump threshold. A result waits in the output register
// while the next sample is taken; the unwrap step holds only when that
// register is still occupied.
// ----------------------------------------------------------------------------
module phase_unwrapper (
   input  logic                                clock,
   input  logic                                reset,
   phu_req_if.sink                             req_chan,
   phu_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [phu_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [phu_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [phu_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import phu_pkg::*;

   phu_state_type state_ff, state_in;

   logic [ANGLE_BITS-1:0] thresh_ff, thresh_in;

   // captured sample description
   logic re_neg_ff, im_neg_ff, re_zero_ff, im_zero_ff, restart_ff;

   logic signed [CORDIC_WIDTH-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_ACC_WIDTH-1:0] z_ff, z_in;
   logic [ITER_BITS-1:0]              iter_ff, iter_in;

   logic signed [PHASE_WIDTH-1:0]      prev_ff, prev_in;
   logic signed [TURN_COUNT_WIDTH-1:0] turns_ff, turns_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [UNWRAP_WIDTH-1:0]     out_unwrap_ff;
   logic signed [PHASE_WIDTH-1:0]      out_phase_ff;
   logic signed [TURN_COUNT_WIDTH-1:0] out_turns_ff;
   logic                               out_indet_ff;

   logic accept, load, iterate, resolve, last_iter, axis_case;

   logic [SAMPLE_WIDTH-1:0] re_mag, im_mag;
   logic signed [CORDIC_WIDTH-1:0] dx, dy;

   logic signed [ANGLE_ACC_WIDTH-1:0] z_round, t_full;
   logic signed [PHASE_WIDTH-1:0]     t_angle, phase, prev_eff, cand;
   logic signed [TURN_COUNT_WIDTH-1:0] turns_eff, turns_new;
   logic signed [PHASE_WIDTH:0]       diff;
   logic [PHASE_WIDTH-1:0]            diff_abs;
   logic                              indet, jump;
   logic signed [UNWRAP_WIDTH-1:0]    unwrapped;

   logic csr_write;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_JUMP_THRESHOLD)) begin
         thresh_in = csr_pwdata[ANGLE_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_JUMP_THRESHOLD) begin
         csr_prdata = CSR_DATA_WIDTH'(thresh_ff);
      end
   end

   // ---------------- sequencer ----------------
   assign accept    = req_chan.valid && req_chan.ready;
   assign last_iter = (iter_ff == ITER_BITS'(CORDIC_ITERATIONS - 1));
   assign axis_case = (req_chan.real_part == '0) || (req_chan.imag_part == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PHU_IDLE: begin
            if (accept) begin
               state_in = axis_case ? PHU_RESOLVE : PHU_ITER;
            end
         end
         PHU_ITER: begin
            if (last_iter) begin
               state_in = PHU_RESOLVE;
            end
         end
         PHU_RESOLVE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = PHU_IDLE;
            end
         end
         default: state_in = PHU_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      iterate        = 1'b0;
      resolve        = 1'b0;
      unique case (state_ff)
         PHU_IDLE:    req_chan.ready = 1'b1;
         PHU_ITER:    iterate = 1'b1;
         PHU_RESOLVE: resolve = !rsp_valid_ff || rsp_chan.ready;
         default:     req_chan.ready = 1'b0;
      endcase
   end

   assign load = accept;

   // ---------------- shared CORDIC unit ----------------
   assign re_mag = req_chan.real_part[SAMPLE_WIDTH-1] ?
                   SAMPLE_WIDTH'(-req_chan.real_part) : SAMPLE_WIDTH'(req_chan.real_part);
   assign im_mag = req_chan.imag_part[SAMPLE_WIDTH-1] ?
                   SAMPLE_WIDTH'(-req_chan.imag_part) : SAMPLE_WIDTH'(req_chan.imag_part);

   assign dx = y_ff >>> iter_ff;
   assign dy = x_ff >>> iter_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      if (load) begin
         x_in    = CORDIC_WIDTH'({re_mag, {GUARD_SHIFT{1'b0}}});
         y_in    = CORDIC_WIDTH'({im_mag, {GUARD_SHIFT{1'b0}}});
         z_in    = '0;
         iter_in = '0;
      end else if (iterate) begin
         // rotate toward the real axis; zero counts as above it
         if (!y_ff[CORDIC_WIDTH-1]) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + phu_atan(5'(iter_ff));
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - phu_atan(5'(iter_ff));
         end
         iter_in = iter_ff + 1'b1;
      end
   end

   // ---------------- unwrap step ----------------
   assign z_round = z_ff + ANGLE_ROUND;
   assign t_full  = z_round >>> (32 - ANGLE_BITS);

   always_comb begin
      if (z_ff < 0) begin
         t_angle = '0;
      end else if (t_full > ANGLE_ACC_WIDTH'(QUARTER_TURN)) begin
         t_angle = QUARTER_TURN;
      end else begin
         t_angle = t_full[PHASE_WIDTH-1:0];
      end
   end

   assign prev_eff  = restart_ff ? '0 : prev_ff;
   assign turns_eff = restart_ff ? '0 : turns_ff;
   assign indet     = re_zero_ff && im_zero_ff;

   always_comb begin
      priority if (indet) begin
         cand = prev_eff;
      end else if (im_zero_ff) begin
         cand = re_neg_ff ? HALF_TURN : '0;
      end else if (re_zero_ff) begin
         cand = im_neg_ff ? -QUARTER_TURN : QUARTER_TURN;
      end else if (!im_neg_ff) begin
         cand = re_neg_ff ? HALF_TURN - t_angle : t_angle;
      end else begin
         cand = re_neg_ff ? t_angle - HALF_TURN : -t_angle;
      end
      // report minus half turn as plus half turn
      phase = (cand == -HALF_TURN) ? HALF_TURN : cand;
   end

   assign diff     = {phase[PHASE_WIDTH-1], phase} - {prev_eff[PHASE_WIDTH-1], prev_eff};
   assign diff_abs = diff[PHASE_WIDTH] ? PHASE_WIDTH'(-diff) : diff[PHASE_WIDTH-1:0];
   assign jump     = !indet && (diff_abs > {1'b0, thresh_ff});

   always_comb begin
      turns_new = turns_eff;
      if (jump) begin
         priority if (phase < 0) begin
            if (turns_eff != TURN_MAX) begin
               turns_new = turns_eff + 1'b1;
            end
         end else if (phase > 0) begin
            if (turns_eff != TURN_MIN) begin
               turns_new = turns_eff - 1'b1;
            end
         end else begin
            turns_new = turns_eff;
         end
      end
   end

   assign unwrapped = {{TURN_COUNT_WIDTH{phase[PHASE_WIDTH-1]}}, phase}
                    + {turns_new[TURN_COUNT_WIDTH-1], turns_new, {ANGLE_BITS{1'b0}}};

   always_comb begin
      prev_in      = prev_ff;
      turns_in     = turns_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (resolve) begin
         prev_in      = phase;
         turns_in     = turns_new;
         rsp_valid_in = 1'b1;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PHU_IDLE;
         thresh_ff    <= THRESH_RESET;
         prev_ff      <= '0;
         turns_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         prev_ff      <= prev_in;
         turns_ff     <= turns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      iter_ff <= iter_in;
      if (load) begin
         re_neg_ff  <= req_chan.real_part[SAMPLE_WIDTH-1];
         im_neg_ff  <= req_chan.imag_part[SAMPLE_WIDTH-1];
         re_zero_ff <= (req_chan.real_part == '0);
         im_zero_ff <= (req_chan.imag_part == '0);
         restart_ff <= req_chan.restart;
      end
      if (resolve) begin
         out_unwrap_ff <= unwrapped;
         out_phase_ff  <= phase;
         out_turns_ff  <= turns_new;
         out_indet_ff  <= indet;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.unwrapped_phase = out_unwrap_ff;
   assign rsp_chan.wrapped_phase   = out_phase_ff;
   assign rsp_chan.turn_count      = out_turns_ff;
   assign rsp_chan.indeterminate   = out_indet_ff;

endmodule

>>> verif/phase_unwrapper_tb.sv
// ----------------------------------------------------------------------------
// phase_unwrapper_tb
// Self-checking testbench for the phase unwrapper. A directed table covers
// the axes, the origin, the minus half turn, restarts and threshold edges; a
// short march steps the turn count up and then down; then rotating phasors
// mixed with axis, origin, small and raw samples run under several jump
// thresholds. Typed table rows are checked against the table, all other results
// against an in-bench CORDIC and unwrap predictor while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module phase_unwrapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import phu_pkg::*;

   localparam longint CYCLE_LIMIT  = 500_000;
   localparam int     PROBE_ROWS   = 23;
   localparam int     RANDOM_ITEMS = 140;
   localparam int     MARCH_STEPS  = 20;
   localparam real    TWO_PI       = 6.283185307179586;

   localparam longint HALF_SPAN    = longint'(1) << (ANGLE_BITS - 1);
   localparam longint QUARTER_SPAN = longint'(1) << (ANGLE_BITS - 2);
   localparam longint FULL_SPAN    = longint'(1) << ANGLE_BITS;
   localparam longint TURN_CEIL    = (longint'(1) << (TURN_COUNT_WIDTH - 1)) - 1;
   localparam longint TURN_FLOOR   = -(longint'(1) << (TURN_COUNT_WIDTH - 1));
   localparam longint DEFAULT_JUMP = ((longint'(280) << ANGLE_BITS) + 180) / 360;
   localparam longint SAMPLE_HI    = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAMPLE_LO    = -(longint'(1) << (SAMPLE_WIDTH - 1));

   localparam logic [CSR_ADDR_WIDTH-1:0] THRESHOLD_ADDR =
      CSR_ADDR_WIDTH'(4 * int'(CSR_IDX_JUMP_THRESHOLD));
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR =
      CSR_ADDR_WIDTH'(4 * (int'(CSR_IDX_JUMP_THRESHOLD) + 1));

   typedef struct packed {
      logic signed [UNWRAP_WIDTH-1:0]     unwrapped;
      logic signed [PHASE_WIDTH-1:0]      wrapped;
      logic signed [TURN_COUNT_WIDTH-1:0] turns;
      logic                               indet;
   } phase_result_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0]     re;
      logic signed [SAMPLE_WIDTH-1:0]     im;
      logic                               restart;
      logic                               typed;
      logic signed [UNWRAP_WIDTH-1:0]     unwrapped;
      logic signed [PHASE_WIDTH-1:0]      wrapped;
      logic signed [TURN_COUNT_WIDTH-1:0] turns;
      logic                               indet;
   } probe_row_type;

   // typed rows assume the reset threshold and the state left by earlier rows
   probe_row_type probe_table [PROBE_ROWS] = '{
      '{24'sd0, 24'sd0, 1'b0, 1'b1, 33'sd0, 17'sd0, 16'sd0, 1'b1},
      '{24'sd8388607, 24'sd0, 1'b0, 1'b1, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{24'sd0, 24'sd8388607, 1'b0, 1'b1, 33'sd16384, 17'sd16384, 16'sd0, 1'b0},
      '{-24'sd8388608, 24'sd0, 1'b0, 1'b1, 33'sd32768, 17'sd32768, 16'sd0, 1'b0},
      '{24'sd0, -24'sd8388608, 1'b0, 1'b1, -33'sd16384, -17'sd16384, 16'sd0, 1'b0},
      '{24'sd0, 24'sd0, 1'b0, 1'b1, -33'sd16384, -17'sd16384, 16'sd0, 1'b1},
      '{24'sd8388607, 24'sd8388607, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{-24'sd8388608, -24'sd8388608, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{-24'sd8388608, 24'sd1, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{-24'sd8388608, -24'sd1, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{24'sd1, -24'sd8388608, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{-24'sd1, 24'sd1, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{24'sd1, -24'sd1, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{-24'sd8388608, 24'sd8388607, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{24'sd8388607, -24'sd8388608, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{24'sd0, 24'sd0, 1'b1, 1'b1, 33'sd0, 17'sd0, 16'sd0, 1'b1},
      '{-24'sd1, 24'sd0, 1'b0, 1'b1, 33'sd32768, 17'sd32768, 16'sd0, 1'b0},
      '{-24'sd5, -24'sd1, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{24'sd0, -24'sd1, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{24'sd3, 24'sd4, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{-24'sd3, -24'sd4, 1'b1, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0},
      '{-24'sd8388608, 24'sd0, 1'b1, 1'b1, 33'sd32768, 17'sd32768, 16'sd0, 1'b0},
      '{24'sd0, 24'sd1, 1'b0, 1'b0, 33'sd0, 17'sd0, 16'sd0, 1'b0}
   };

   // round(atan(2^-i) / (2 pi) * 2^32)
   longint atan_steps [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   logic                       clock;
   logic                       reset;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   phu_req_if req_if ();
   phu_rsp_if rsp_if ();

   phase_unwrapper DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state and configuration
   longint                last_phase;
   longint                turn_total;
   logic [ANGLE_BITS-1:0] jump_limit;

   phase_result_type expected_results [$];

   bit     steady_flow;
   int     rsp_hold_request;
   int     error_count;
   longint cycle_count;
   int     samples_sent;
   int     results_checked;
   int     origin_count;
   int     restart_count;
   int     turn_moves;
   int     thresholds_used;
   longint turn_peak;
   longint turn_low;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int pick_pause();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(12, 45);
   endfunction

   // first-quadrant angle of two positive magnitudes, ANGLE_BITS units
   function automatic longint quadrant_angle(input longint mag_x, input longint mag_y);
      longint x, y, z, dx, dy, q;
      x = mag_x <<< GUARD_SHIFT;
      y = mag_y <<< GUARD_SHIFT;
      z = 0;
      for (int i = 0; i < ((CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS); i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_steps[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_steps[i];
         end
      end
      if (z < 0)
         return 0;
      q = (z + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
      return (q > QUARTER_SPAN) ? QUARTER_SPAN : q;
   endfunction

   function automatic phase_result_type unwrap_sample(input longint re, input longint im,
                                                      input bit restart);
      phase_result_type res;
      longint           ph, t, jump;
      if (restart) begin
         last_phase = 0;
         turn_total = 0;
         restart_count++;
      end
      res.indet = (re == 0 && im == 0);
      if (res.indet) begin
         // origin: hold the state and repeat the previous phase
         ph = last_phase;
         origin_count++;
      end else begin
         if (im == 0)
            ph = (re < 0) ? HALF_SPAN : 0;
         else if (re == 0)
            ph = (im < 0) ? -QUARTER_SPAN : QUARTER_SPAN;
         else begin
            t = quadrant_angle((re < 0) ? -re : re, (im < 0) ? -im : im);
            if (im > 0)
               ph = (re > 0) ? t : HALF_SPAN - t;
            else
               ph = (re > 0) ? -t : t - HALF_SPAN;
            if (ph == -HALF_SPAN)
               ph = HALF_SPAN;
         end
         jump = ph - last_phase;
         if (jump < 0)
            jump = -jump;
         if (jump > longint'(jump_limit)) begin
            if (ph < 0 && turn_total < TURN_CEIL) begin
               turn_total++;
               turn_moves++;
            end else if (ph > 0 && turn_total > TURN_FLOOR) begin
               turn_total--;
               turn_moves++;
            end
         end
         last_phase = ph;
      end
      if (turn_total > turn_peak)
         turn_peak = turn_total;
      if (turn_total < turn_low)
         turn_low = turn_total;
      res.unwrapped = UNWRAP_WIDTH'(ph + turn_total * FULL_SPAN);
      res.wrapped   = PHASE_WIDTH'(ph);
      res.turns     = TURN_COUNT_WIDTH'(turn_total);
      return res;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(input real v);
      longint l;
      l = longint'(v);
      if (l > SAMPLE_HI)
         l = SAMPLE_HI;
      if (l < SAMPLE_LO)
         l = SAMPLE_LO;
      return SAMPLE_WIDTH'(l);
   endfunction

   // call at a falling edge; returns at a falling edge after the pause
   task automatic offer_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                               input logic signed [SAMPLE_WIDTH-1:0] im,
                               input logic restart, input bit typed,
                               input phase_result_type typed_result);
      phase_result_type predicted;
      int               gap;
      req_if.valid     <= 1'b1;
      req_if.real_part <= re;
      req_if.imag_part <= im;
      req_if.restart   <= restart;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      predicted = unwrap_sample(longint'(re), longint'(im), restart);
      expected_results.push_back(typed ? typed_result : predicted);
      samples_sent++;
      @(negedge clock);
      gap = pick_pause();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do
         @(negedge clock);
      while (expected_results.size() != 0);
   endtask

   task automatic csr_xfer(input logic wr, input logic [CSR_ADDR_WIDTH-1:0] addr,
                           input logic [CSR_DATA_WIDTH-1:0] data,
                           output logic [CSR_DATA_WIDTH-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      if (wr && addr == THRESHOLD_ADDR)
         jump_limit = data[ANGLE_BITS-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_threshold();
      logic [CSR_DATA_WIDTH-1:0] rd;
      csr_xfer(1'b0, THRESHOLD_ADDR, '0, rd);
      if (rd !== CSR_DATA_WIDTH'(jump_limit)) begin
         $error("jump_threshold: expected %0d, got %0d", jump_limit, rd);
         error_count++;
      end
   endtask

   task automatic set_threshold(input logic [ANGLE_BITS-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] rd;
      csr_xfer(1'b1, THRESHOLD_ADDR, CSR_DATA_WIDTH'(value), rd);
      thresholds_used++;
      check_threshold();
   endtask

   // three axis samples per turn; the jump from +H to -Q exceeds a half turn
   task automatic march_turns(input bit upward);
      phase_result_type none;
      none = '0;
      offer_sample(SAMPLE_WIDTH'(SAMPLE_HI), '0, 1'b1, 1'b0, none);
      repeat (MARCH_STEPS) begin
         if (upward) begin
            offer_sample(SAMPLE_WIDTH'(SAMPLE_LO), '0, 1'b0, 1'b0, none);
            offer_sample('0, SAMPLE_WIDTH'(SAMPLE_LO), 1'b0, 1'b0, none);
         end else begin
            offer_sample('0, SAMPLE_WIDTH'(SAMPLE_LO), 1'b0, 1'b0, none);
            offer_sample(SAMPLE_WIDTH'(SAMPLE_LO), '0, 1'b0, 1'b0, none);
         end
         offer_sample(SAMPLE_WIDTH'(SAMPLE_HI), '0, 1'b0, 1'b0, none);
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int stall_left;
      int hold;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_if.ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_pause();
         end
      end
   end

   always @(posedge clock) begin
      phase_result_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with no expectation waiting: unwrapped_phase %0d",
                   rsp_if.unwrapped_phase);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_if.unwrapped_phase !== want.unwrapped) begin
               $error("unwrapped_phase: expected %0d, got %0d", want.unwrapped,
                      rsp_if.unwrapped_phase);
               error_count++;
            end
            if (rsp_if.wrapped_phase !== want.wrapped) begin
               $error("wrapped_phase: expected %0d, got %0d", want.wrapped,
                      rsp_if.wrapped_phase);
               error_count++;
            end
            if (rsp_if.turn_count !== want.turns) begin
               $error("turn_count: expected %0d, got %0d", want.turns, rsp_if.turn_count);
               error_count++;
            end
            if (rsp_if.indeterminate !== want.indet) begin
               $error("indeterminate: expected %0d, got %0d", want.indet,
                      rsp_if.indeterminate);
               error_count++;
            end
         end
      end
   end

   initial begin
      phase_result_type          typed_result;
      logic [CSR_DATA_WIDTH-1:0] rd;
      logic [ANGLE_BITS-1:0]     phase_limits [4];
      logic signed [SAMPLE_WIDTH-1:0] re, im, v;
      logic                      restart;
      int                        sent, burst_len, kind;
      real                       ang, step, mag;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.real_part = '0;
      req_if.imag_part = '0;
      req_if.restart   = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      steady_flow      = 1'b0;
      rsp_hold_request = 0;
      last_phase       = 0;
      turn_total       = 0;
      turn_peak        = 0;
      turn_low         = 0;
      jump_limit       = ANGLE_BITS'(DEFAULT_JUMP);

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_threshold();

      for (int i = 0; i < PROBE_ROWS; i++) begin
         typed_result.unwrapped = probe_table[i].unwrapped;
         typed_result.wrapped   = probe_table[i].wrapped;
         typed_result.turns     = probe_table[i].turns;
         typed_result.indet     = probe_table[i].indet;
         offer_sample(probe_table[i].re, probe_table[i].im, probe_table[i].restart,
                      probe_table[i].typed, typed_result);
      end
      drain_results();

      // a write to an unmapped address must leave the threshold alone
      csr_xfer(1'b1, SPARE_ADDR, $urandom, rd);
      check_threshold();

      // step the turn count up, then down
      set_threshold(ANGLE_BITS'(HALF_SPAN));
      steady_flow = 1'b1;
      march_turns(1'b1);
      march_turns(1'b0);
      steady_flow = 1'b0;
      drain_results();

      phase_limits[0] = '1;
      phase_limits[1] = ANGLE_BITS'($urandom_range(int'(HALF_SPAN) + 1, int'(FULL_SPAN) - 2));
      phase_limits[2] = ANGLE_BITS'(HALF_SPAN);
      phase_limits[3] = ANGLE_BITS'(DEFAULT_JUMP);

      typed_result = '0;
      for (int p = 0; p < 4; p++) begin
         set_threshold(phase_limits[p]);
         if (p == 1) begin
            // stall the result side long enough to back up the sample side
            rsp_hold_request = 300;
            steady_flow = 1'b1;
            repeat (8)
               offer_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom), 1'b0, 1'b0,
                            typed_result);
            steady_flow = 1'b0;
            drain_results();
         end
         sent = 0;
         while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(10, 40);
            steady_flow = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0:       mag = real'(SAMPLE_HI);
               1:       mag = real'($urandom_range(1, int'(SAMPLE_HI)));
               default: mag = real'($urandom_range(1, 1000));
            endcase
            ang  = real'($urandom_range(0, 999)) / 1000.0;
            step = (real'($urandom_range(0, 900)) - 450.0) / 1000.0;
            repeat (burst_len) begin
               kind    = $urandom_range(0, 99);
               restart = ($urandom_range(0, 32) == 0);
               if (kind < 55) begin
                  ang = ang + step;
                  re  = to_sample(mag * $cos(TWO_PI * ang));
                  im  = to_sample(mag * $sin(TWO_PI * ang));
               end else if (kind < 65) begin
                  case ($urandom_range(0, 2))
                     0:       v = SAMPLE_WIDTH'(SAMPLE_HI);
                     1:       v = SAMPLE_WIDTH'(SAMPLE_LO);
                     default: v = SAMPLE_WIDTH'($urandom);
                  endcase
                  re = $urandom_range(0, 1) ? v : '0;
                  im = (re == '0) ? v : '0;
               end else if (kind < 70) begin
                  re = '0;
                  im = '0;
               end else if (kind < 85) begin
                  re = SAMPLE_WIDTH'($urandom);
                  im = SAMPLE_WIDTH'($urandom);
               end else begin
                  re = SAMPLE_WIDTH'(int'($urandom_range(0, 8)) - 4);
                  im = SAMPLE_WIDTH'(int'($urandom_range(0, 8)) - 4);
               end
               offer_sample(re, im, restart, 1'b0, typed_result);
               sent++;
            end
         end
         steady_flow = 1'b0;
         drain_results();
      end

      repeat (40) @(posedge clock);

      $display("Summary: %0d samples (%0d at the origin, %0d restarts), %0d results checked",
               samples_sent, origin_count, restart_count, results_checked);
      $display("Summary: %0d threshold settings, turn count moved %0d times over %0d..%0d",
               thresholds_used, turn_moves, turn_low, turn_peak);
      if (error_count == 0 && expected_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/phu_pkg.sv
hw/rtl/phu_req_if.sv
hw/rtl/phu_rsp_if.sv
hw/rtl/phase_unwrapper.sv
verif/phase_unwrapper_tb.sv
